// ===== rtl/fwrs_pkg.sv =====
// Shared types, codes and a CRC-32 helper for the firmware image receive session.
package fwrs_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_CHUNK = 2'd1,
		CMD_END   = 2'd2,
		CMD_ABORT = 2'd3
	} command_t;

	typedef enum logic [2:0] {
		RC_OK     = 3'd0,
		RC_ARG    = 3'd1,
		RC_STATE  = 3'd2,
		RC_OFFSET = 3'd3,
		RC_SIZE   = 3'd4,
		RC_FLASH  = 3'd5,
		RC_CRC    = 3'd6
	} result_code_t;

	// Image of one register bit after a number of zero-byte CRC steps.
	// Only ever called with constant arguments, so it folds at elaboration.
	function automatic logic [31:0] crc_col(input int unsigned bit_pos,
		input int unsigned num_bytes);
		logic [31:0] c;
		c = 32'd1 << bit_pos;
		for (int unsigned i = 0; i < num_bytes * 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

// ===== rtl/firmware_image_receive_session_top.sv =====
// Top level of the firmware image receive session: request capture, checks, session state.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | to block  | in_valid / in_stall | command, image_length, image_crc,
//          |           |                     | chunk_offset, chunk_len, chunk_data, flash_ok
//  out     | from block| out_valid/out_stall | result_code, session_state, bytes_received,
//          |           |                     | image_done
//
// Each request is first held in the capture register; then the CRC lanes, the
// merge stage and the checks run on it and the session registers update.
// The capture register holds one request; in_stall is high while it is occupied.
// A result waits in the output register; a request that finishes while that register
// is still stalled stays in the capture register until the register frees.
// Reset puts the session in idle with size, expected CRC, count and CRC cleared.
module firmware_image_receive_session_top #(
	parameter int unsigned CHUNK_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] image_length,
	input  logic [31:0] image_crc,
	input  logic [31:0] chunk_offset,
	input  logic [3:0]  chunk_len,
	input  logic [63:0] chunk_data,
	input  logic        flash_ok,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_code,
	output logic [1:0]  session_state,
	output logic [31:0] bytes_received,
	output logic        image_done
);
	import fwrs_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RECV = 2'd1,
		PH_DONE = 2'd2,
		PH_ERR  = 2'd3
	} phase_t;

	logic        valid_s1;
	command_t    command_s1;
	logic [31:0] image_length_s1;
	logic [31:0] image_crc_s1;
	logic [31:0] chunk_offset_s1;
	logic [3:0]  chunk_len_s1;
	logic [63:0] chunk_data_s1;
	logic        flash_ok_s1;

	phase_t      phase_q;
	logic [31:0] total_size_q;
	logic [31:0] target_crc_q;
	logic [31:0] count_q;
	logic [31:0] crc_q;

	logic         out_valid_q;
	result_code_t result_code_q;
	logic [1:0]   session_state_q;
	logic [31:0]  bytes_received_q;
	logic         image_done_q;

	logic [31:0] contrib [CHUNK_BYTES];
	logic [31:0] crc_next;

	logic         accept;
	logic         process;
	phase_t       phase_d;
	logic [31:0]  total_size_d;
	logic [31:0]  target_crc_d;
	logic [31:0]  count_d;
	logic [31:0]  crc_d;
	result_code_t rc_d;
	logic         done_d;

	assign in_stall = valid_s1;
	assign accept   = in_valid && !in_stall;
	assign process  = valid_s1 && (!out_valid_q || !out_stall);

	for (genvar k = 0; k < CHUNK_BYTES; k++) begin : g_lane
		fwrs_lane #(
			.LANE  (k),
			.LANES (CHUNK_BYTES)
		) u_lane (
			.chunk_data (chunk_data_s1),
			.chunk_len  (chunk_len_s1),
			.contrib    (contrib[k])
		);
	end

	fwrs_merge #(
		.LANES (CHUNK_BYTES)
	) u_merge (
		.contrib   (contrib),
		.crc_in    (crc_q),
		.chunk_len (chunk_len_s1),
		.crc_out   (crc_next)
	);

	always_comb begin
		phase_d      = phase_q;
		total_size_d = total_size_q;
		target_crc_d = target_crc_q;
		count_d      = count_q;
		crc_d        = crc_q;
		rc_d         = RC_OK;
		done_d       = 1'b0;
		unique case (command_s1)
			CMD_BEGIN: begin
				priority if (image_length_s1 == 32'd0) begin
					rc_d = RC_ARG;
				end else if (phase_q == PH_RECV) begin
					rc_d = RC_STATE;
				end else begin
					total_size_d = image_length_s1;
					target_crc_d = image_crc_s1;
					count_d      = '0;
					crc_d        = '0;
					phase_d      = flash_ok_s1 ? PH_RECV : PH_ERR;
					rc_d         = flash_ok_s1 ? RC_OK : RC_FLASH;
				end
			end
			CMD_CHUNK: begin
				priority if (chunk_len_s1 == 4'd0 || chunk_len_s1 > 4'(CHUNK_BYTES)) begin
					rc_d = RC_ARG;
				end else if (phase_q != PH_RECV) begin
					rc_d = RC_STATE;
				end else if (chunk_offset_s1 != count_q) begin
					rc_d = RC_OFFSET;
				end else if (32'(chunk_len_s1) > total_size_q - count_q) begin
					phase_d = PH_ERR;
					rc_d    = RC_SIZE;
				end else if (!flash_ok_s1) begin
					phase_d = PH_ERR;
					rc_d    = RC_FLASH;
				end else begin
					crc_d   = crc_next;
					count_d = count_q + 32'(chunk_len_s1);
				end
			end
			CMD_END: begin
				priority if (phase_q != PH_RECV) begin
					rc_d = RC_STATE;
				end else if (count_q != total_size_q) begin
					phase_d = PH_ERR;
					rc_d    = RC_SIZE;
				end else if (crc_q != target_crc_q) begin
					phase_d = PH_ERR;
					rc_d    = RC_CRC;
				end else if (!flash_ok_s1) begin
					phase_d = PH_ERR;
					rc_d    = RC_FLASH;
				end else begin
					phase_d = PH_DONE;
					done_d  = 1'b1;
				end
			end
			CMD_ABORT: begin
				phase_d = PH_IDLE;
				count_d = '0;
				crc_d   = '0;
			end
			default: begin
				rc_d = RC_OK;
			end
		endcase
	end

	// Capture register for one request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1      <= command_t'(command);
			image_length_s1 <= image_length;
			image_crc_s1    <= image_crc;
			chunk_offset_s1 <= chunk_offset;
			chunk_len_s1    <= chunk_len;
			chunk_data_s1   <= chunk_data;
			flash_ok_s1     <= flash_ok;
		end
	end

	// Session registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			total_size_q <= '0;
			target_crc_q <= '0;
			count_q      <= '0;
			crc_q        <= '0;
		end else if (process) begin
			phase_q      <= phase_d;
			total_size_q <= total_size_d;
			target_crc_q <= target_crc_d;
			count_q      <= count_d;
			crc_q        <= crc_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			result_code_q    <= rc_d;
			session_state_q  <= phase_d;
			bytes_received_q <= count_d;
			image_done_q     <= done_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_code    = result_code_q;
	assign session_state  = session_state_q;
	assign bytes_received = bytes_received_q;
	assign image_done     = image_done_q;

	// The byte count never runs past the announced image size.
	a_count_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= total_size_q)
		else $error("byte count exceeds image size");

	// A completed image is always reported as ok and done.
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && image_done) |->
			(result_code == RC_OK && session_state == PH_DONE))
		else $error("image_done without ok result and done state");

	// An idle session reports no received bytes.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && session_state == PH_IDLE) |-> (bytes_received == 32'd0))
		else $error("idle session with nonzero byte count");

	// A request that completes frees the capture register.
	a_capture_frees: assert property (@(posedge clk) disable iff (!arst_n)
		process |=> !valid_s1)
		else $error("capture register still busy after completion");

endmodule

// ===== rtl/fwrs_lane.sv =====
// One CRC lane: picks its byte from the right-aligned chunk and projects it to the frame end.
module fwrs_lane #(
	parameter int unsigned LANE  = 0,
	parameter int unsigned LANES = 8
) (
	input  logic [63:0] chunk_data,
	input  logic [3:0]  chunk_len,
	output logic [31:0] contrib
);
	import fwrs_pkg::*;

	// The valid bytes sit in the last chunk_len lanes of the frame.
	logic [4:0]  pos;
	logic [2:0]  src;
	logic        used;
	logic [7:0]  lane_byte;
	logic [31:0] terms [8];

	assign pos  = 5'(LANE) + {1'b0, chunk_len};
	assign used = pos >= 5'(LANES);
	assign src  = 3'(pos - 5'(LANES));

	always_comb begin
		lane_byte = '0;
		if (used) begin
			lane_byte = 8'(chunk_data >> {src, 3'b000});
		end
	end

	for (genvar b = 0; b < 8; b++) begin : g_col
		localparam logic [31:0] COL = crc_col(b, LANES - LANE);
		assign terms[b] = lane_byte[b] ? COL : 32'd0;
	end

	always_comb begin
		contrib = '0;
		for (int b = 0; b < 8; b++) begin
			contrib ^= terms[b];
		end
	end

endmodule

// ===== rtl/fwrs_merge.sv =====
// Merges the lane contributions with the running CRC advanced by the chunk length.
module fwrs_merge #(
	parameter int unsigned LANES = 8
) (
	input  logic [31:0] contrib [LANES],
	input  logic [31:0] crc_in,
	input  logic [3:0]  chunk_len,
	output logic [31:0] crc_out
);
	import fwrs_pkg::*;

	logic [31:0] state_in;
	logic [31:0] adv_terms [LANES][32];
	logic [31:0] adv [LANES];
	logic [31:0] adv_sel;
	logic [31:0] data_sum;

	assign state_in = ~crc_in;

	// adv[n] is the register state carried through n+1 byte steps.
	for (genvar n = 0; n < LANES; n++) begin : g_adv
		for (genvar b = 0; b < 32; b++) begin : g_col
			localparam logic [31:0] COL = crc_col(b, n + 1);
			assign adv_terms[n][b] = state_in[b] ? COL : 32'd0;
		end
		always_comb begin
			adv[n] = '0;
			for (int b = 0; b < 32; b++) begin
				adv[n] ^= adv_terms[n][b];
			end
		end
	end

	always_comb begin
		adv_sel  = state_in;
		data_sum = '0;
		for (int n = 0; n < LANES; n++) begin
			if (chunk_len == 4'(n + 1)) begin
				adv_sel = adv[n];
			end
			data_sum ^= contrib[n];
		end
		crc_out = ~(adv_sel ^ data_sum);
	end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the firmware image receive session block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fwrs_pkg::*;

	localparam int unsigned CHUNK_BYTES = 8;
	localparam int unsigned ITEM_TARGET = 1050;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned PRESSURE_AT = 250;
	localparam int unsigned PRESSURE_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned MAX_PRINTED = 40;

	typedef enum logic [1:0] {
		PHASE_IDLE      = 2'd0,
		PHASE_RECEIVING = 2'd1,
		PHASE_DONE      = 2'd2,
		PHASE_ERROR     = 2'd3
	} session_phase_t;

	typedef struct {
		command_t    cmd;
		logic [31:0] image_bytes;
		logic [31:0] crc;
		logic [31:0] offset;
		logic [3:0]  len;
		logic [63:0] data;
		logic        fok;
	} request_t;

	typedef struct {
		result_code_t   code;
		session_phase_t phase;
		logic [31:0]    count;
		logic           done;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = 2'd0;
	logic [31:0] image_length = 32'd0;
	logic [31:0] image_crc = 32'd0;
	logic [31:0] chunk_offset = 32'd0;
	logic [3:0]  chunk_len = 4'd0;
	logic [63:0] chunk_data = 64'd0;
	logic        flash_ok = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  result_code;
	logic [1:0]  session_state;
	logic [31:0] bytes_received;
	logic        image_done;

	request_t    pending_requests[$];
	outcome_t    expected_outcomes[$];
	request_t    offered;
	outcome_t    want;

	// Session model, advanced once per accepted request.
	session_phase_t sess_phase = PHASE_IDLE;
	logic [31:0]    sess_size = 32'd0;
	logic [31:0]    sess_target_crc = 32'd0;
	logic [31:0]    sess_count = 32'd0;
	logic [31:0]    sess_crc = 32'd0;

	int unsigned error_count = 0;
	int unsigned results_seen = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned send_quiet = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;
	int unsigned hold_left = 0;
	logic        stall_next;

	firmware_image_receive_session_top #(
		.CHUNK_BYTES(CHUNK_BYTES)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.image_length  (image_length),
		.image_crc     (image_crc),
		.chunk_offset  (chunk_offset),
		.chunk_len     (chunk_len),
		.chunk_data    (chunk_data),
		.flash_ok      (flash_ok),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_code   (result_code),
		.session_state (session_state),
		.bytes_received(bytes_received),
		.image_done    (image_done)
	);

	always #5 clk = ~clk;

	// Reflected CRC-32, inverted on the way in and out of every update.
	function automatic logic [31:0] crc32_add(input logic [31:0] crc, input logic [63:0] data,
		input int unsigned nbytes);
		logic [31:0] c;
		c = ~crc;
		for (int unsigned i = 0; i < nbytes && i < 8; i++) begin
			c = c ^ {24'd0, data[8*i +: 8]};
			for (int k = 0; k < 8; k++) begin
				c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
			end
		end
		return ~c;
	endfunction

	function automatic void predict_session(input request_t r);
		outcome_t o;
		o.code = RC_OK;
		o.done = 1'b0;
		case (r.cmd)
			CMD_BEGIN: begin
				if (r.image_bytes == 32'd0) begin
					o.code = RC_ARG;
				end else if (sess_phase == PHASE_RECEIVING) begin
					o.code = RC_STATE;
				end else begin
					sess_size = r.image_bytes;
					sess_target_crc = r.crc;
					sess_count = 32'd0;
					sess_crc = 32'd0;
					sess_phase = PHASE_RECEIVING;
					if (!r.fok) begin
						sess_phase = PHASE_ERROR;
						o.code = RC_FLASH;
					end
				end
			end
			CMD_CHUNK: begin
				if (r.len == 4'd0 || r.len > CHUNK_BYTES) begin
					o.code = RC_ARG;
				end else if (sess_phase != PHASE_RECEIVING) begin
					o.code = RC_STATE;
				end else if (r.offset != sess_count) begin
					o.code = RC_OFFSET;
				end else if ({28'd0, r.len} > sess_size - sess_count) begin
					sess_phase = PHASE_ERROR;
					o.code = RC_SIZE;
				end else if (!r.fok) begin
					sess_phase = PHASE_ERROR;
					o.code = RC_FLASH;
				end else begin
					sess_crc = crc32_add(sess_crc, r.data, r.len);
					sess_count = sess_count + r.len;
				end
			end
			CMD_END: begin
				if (sess_phase != PHASE_RECEIVING) begin
					o.code = RC_STATE;
				end else if (sess_count != sess_size) begin
					sess_phase = PHASE_ERROR;
					o.code = RC_SIZE;
				end else if (sess_crc != sess_target_crc) begin
					sess_phase = PHASE_ERROR;
					o.code = RC_CRC;
				end else if (!r.fok) begin
					sess_phase = PHASE_ERROR;
					o.code = RC_FLASH;
				end else begin
					sess_phase = PHASE_DONE;
					o.done = 1'b1;
				end
			end
			default: begin
				sess_phase = PHASE_IDLE;
				sess_count = 32'd0;
				sess_crc = 32'd0;
			end
		endcase
		o.phase = sess_phase;
		o.count = sess_count;
		expected_outcomes.push_back(o);
	endfunction

	task automatic report_error(input string msg);
		if (error_count < MAX_PRINTED)
			$display("ERROR: %s", msg);
		error_count++;
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Fields a command does not use stay random.
	function automatic request_t random_request();
		request_t r;
		r.cmd = command_t'($urandom_range(0, 3));
		r.image_bytes = $urandom();
		r.crc = $urandom();
		r.offset = $urandom();
		r.len = 4'($urandom_range(0, 15));
		r.data = {$urandom(), $urandom()};
		r.fok = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic queue_begin(input logic [31:0] nbytes, input logic [31:0] crc,
		input logic fok);
		request_t r;
		r = random_request();
		r.cmd = CMD_BEGIN;
		r.image_bytes = nbytes;
		r.crc = crc;
		r.fok = fok;
		pending_requests.push_back(r);
	endtask

	task automatic queue_chunk(input logic [31:0] offset, input logic [3:0] len,
		input logic [63:0] data, input logic fok);
		request_t r;
		r = random_request();
		r.cmd = CMD_CHUNK;
		r.offset = offset;
		r.len = len;
		r.data = data;
		r.fok = fok;
		pending_requests.push_back(r);
	endtask

	task automatic queue_end(input logic fok);
		request_t r;
		r = random_request();
		r.cmd = CMD_END;
		r.fok = fok;
		pending_requests.push_back(r);
	endtask

	task automatic queue_abort();
		request_t r;
		r = random_request();
		r.cmd = CMD_ABORT;
		pending_requests.push_back(r);
	endtask

	// One complete in-order transfer, now and then with a broken request mixed in.
	task automatic queue_image_session();
		request_t    chunks[$];
		request_t    piece;
		request_t    broken;
		logic [31:0] nbytes;
		logic [31:0] crc;
		logic [31:0] filled;
		int unsigned room;
		int unsigned len;
		nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 96) : $urandom_range(1, 32);
		crc = 32'd0;
		filled = 32'd0;
		while (filled < nbytes) begin
			room = nbytes - filled;
			len = $urandom_range(1, (room < 8) ? room : 8);
			piece = random_request();
			piece.cmd = CMD_CHUNK;
			piece.offset = filled;
			piece.len = 4'(len);
			piece.fok = 1'b1;
			crc = crc32_add(crc, piece.data, len);
			filled = filled + len;
			chunks.push_back(piece);
		end
		if ($urandom_range(0, 9) == 0)
			crc = crc ^ (32'd1 << $urandom_range(0, 31));
		queue_begin(nbytes, crc, $urandom_range(0, 29) != 0);
		foreach (chunks[i]) begin
			if ($urandom_range(0, 29) == 0) begin
				broken = chunks[i];
				case ($urandom_range(0, 5))
					0: begin
						broken.offset = broken.offset ^ (32'd1 << $urandom_range(0, 31));
						pending_requests.push_back(broken);
					end
					1: begin
						broken.fok = 1'b0;
						pending_requests.push_back(broken);
					end
					2: begin
						broken.len = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
						pending_requests.push_back(broken);
					end
					3: begin
						room = nbytes - chunks[i].offset;
						if (room < 8) begin
							broken.len = 4'(room + 1);
							pending_requests.push_back(broken);
						end
					end
					4: queue_abort();
					default: queue_end(1'b1);
				endcase
			end
			pending_requests.push_back(chunks[i]);
		end
		queue_end($urandom_range(0, 29) != 0);
	endtask

	initial begin
		logic [31:0] crc3;
		logic [31:0] crc9;
		logic        after_noise;
		request_t    r;
		crc3 = crc32_add(32'd0, {64{1'b1}}, 3);
		crc9 = crc32_add(crc32_add(32'd0, 64'd0, 8), {64{1'b1}}, 1);

		queue_end(1'b1);
		queue_chunk(32'd0, 4'd4, {$urandom(), $urandom()}, 1'b1);
		queue_chunk(32'd0, 4'd0, {$urandom(), $urandom()}, 1'b1);
		queue_chunk(32'd0, 4'd15, {$urandom(), $urandom()}, 1'b1);
		queue_begin(32'd0, 32'd0, 1'b1);
		queue_begin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_begin(32'd3, crc3, 1'b1);
		queue_begin(32'd5, 32'd0, 1'b1);
		queue_chunk(32'd1, 4'd3, {64{1'b1}}, 1'b1);
		queue_chunk(32'd0, 4'd4, {64{1'b1}}, 1'b1);
		queue_begin(32'd3, crc3, 1'b1);
		queue_chunk(32'd0, 4'd3, {64{1'b1}}, 1'b1);
		queue_end(1'b0);
		queue_begin(32'd3, crc3, 1'b1);
		queue_chunk(32'd0, 4'd2, {64{1'b1}}, 1'b0);
		queue_begin(32'd9, crc9, 1'b1);
		queue_chunk(32'd0, 4'd8, 64'd0, 1'b1);
		queue_chunk(32'd8, 4'd1, {64{1'b1}}, 1'b1);
		queue_end(1'b1);
		queue_end(1'b1);
		queue_begin(32'd2, ~crc3, 1'b1);
		queue_chunk(32'd0, 4'd2, {64{1'b1}}, 1'b1);
		queue_end(1'b1);
		queue_begin(32'd4, 32'd0, 1'b1);
		queue_chunk(32'd0, 4'd1, 64'd0, 1'b1);
		queue_end(1'b1);
		queue_abort();
		queue_abort();

		after_noise = 1'b0;
		while (pending_requests.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 9) < 7) begin
				if (after_noise && $urandom_range(0, 3) != 0)
					queue_abort();
				queue_image_session();
				after_noise = 1'b0;
			end else begin
				repeat ($urandom_range(1, 4)) begin
					r = random_request();
					if ($urandom_range(0, 1) == 0)
						r.offset = $urandom_range(0, 16);
					pending_requests.push_back(r);
				end
				after_noise = 1'b1;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_requests.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Request driver: a stalled request is held unchanged until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_BEGIN;
			image_length <= 32'd0;
			image_crc <= 32'd0;
			chunk_offset <= 32'd0;
			chunk_len <= 4'd0;
			chunk_data <= 64'd0;
			flash_ok <= 1'b0;
			send_gap = 0;
			send_quiet = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_session(offered);
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0 || pending_requests.size() == 0) begin
					in_valid <= 1'b0;
					if (send_gap > 0)
						send_gap = send_gap - 1;
				end else begin
					offered = pending_requests.pop_front();
					command <= offered.cmd;
					image_length <= offered.image_bytes;
					image_crc <= offered.crc;
					chunk_offset <= offered.offset;
					chunk_len <= offered.len;
					chunk_data <= offered.data;
					flash_ok <= offered.fok;
					in_valid <= 1'b1;
					if (send_quiet > 0) begin
						send_quiet = send_quiet - 1;
						send_gap = 0;
					end else begin
						send_gap = pick_gap();
						if ($urandom_range(0, 39) == 0)
							send_quiet = $urandom_range(20, 60);
					end
				end
			end
		end
	end

	// Result monitor and receiver stall pattern, including one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			calm_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_outcomes.size() == 0) begin
					report_error($sformatf("result %0d arrived with nothing expected",
						results_seen));
				end else begin
					want = expected_outcomes.pop_front();
					if (result_code !== want.code)
						report_error($sformatf("result %0d: result_code %0d, expected %0d",
							results_seen, result_code, want.code));
					if (session_state !== want.phase)
						report_error($sformatf("result %0d: session_state %0d, expected %0d",
							results_seen, session_state, want.phase));
					if (bytes_received !== want.count)
						report_error($sformatf("result %0d: bytes_received %0d, expected %0d",
							results_seen, bytes_received, want.count));
					if (image_done !== want.done)
						report_error($sformatf("result %0d: image_done %0b, expected %0b",
							results_seen, image_done, want.done));
				end
				results_seen++;
				if (results_seen == PRESSURE_AT)
					hold_left = PRESSURE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				stall_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				stall_next = 1'b1;
			end else if (calm_left > 0) begin
				calm_left = calm_left - 1;
				stall_next = 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
				if ($urandom_range(0, 59) == 0)
					calm_left = $urandom_range(20, 60);
			end
			out_stall <= stall_next;
		end
	end

	// Ends a hung run: no request or result has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule
